FILE: rtl/urlencoded_form_field_extractor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the urlencoded form field extractor
// Shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef URLENCODED_FORM_FIELD_EXTRACTOR_DEFINES_SVH
`define URLENCODED_FORM_FIELD_EXTRACTOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define UFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition at one edge implies a consequence at the next edge
`define UFE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Types and constants of the urlencoded form field extractor
// ----------------------------------------------------------------------------
`default_nettype none

package ufe_pkg;

  // limits
  localparam int unsigned MAX_KEY_CHARS = 8;
  localparam int unsigned MAX_CAPACITY  = 256;
  localparam int unsigned CAP_W         = 9;
  localparam int unsigned KLEN_W        = 4;
  localparam int unsigned KEY_W         = 64;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_BYTES      = 2'd0,
    CFG_KEY_LENGTH     = 2'd1,
    CFG_VALUE_CAPACITY = 2'd2
  } cfg_reg_e;

  // lookup phase
  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // input item
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       key_found;
    logic       lookup_done;
    logic       run_last;
  } out_item_t;

  // working state of one byte step
  typedef struct packed {
    phase_e          phase;
    logic [3:0]      kp;
    logic [7:0]      ec;
    logic [1:0]      pc;
    logic [7:0]      pch;
    logic [1:0]      n;
    out_item_t [1:0] res;
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/urlencoded_form_field_extractor.sv
// ----------------------------------------------------------------------------
// urlencoded_form_field_extractor
// Finds the first form segment "key=" and streams out its percent-decoded
// value, then reports found or not found once per body.
// ----------------------------------------------------------------------------
// A result is offered in the cycle after its byte transfer.
// Throughput: one byte per cycle while each byte gives at most one result
// and the sink is ready; a byte with two results holds the input until the
// two-entry result buffer, draining one result per cycle, is down to one.
// Reset (rst_ni low, asynchronous): registers to defaults (capacity 256),
// phase back to key matching, counters cleared, result buffer emptied.
`default_nettype none

`include "urlencoded_form_field_extractor_defines.svh"

module urlencoded_form_field_extractor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_addr_i,
  input  wire logic [ufe_pkg::KEY_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire ufe_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output ufe_pkg::out_item_t                  out_data_o
);

  // configuration
  logic [ufe_pkg::KEY_W-1:0]  key_bytes_q;
  logic [ufe_pkg::KLEN_W-1:0] key_len_q;
  logic [ufe_pkg::CAP_W-1:0]  cap_q;

  // lookup state
  ufe_pkg::phase_e phase_q, phase_d;
  logic [3:0]      kp_q, kp_d;
  logic [7:0]      ec_q, ec_d;
  logic [1:0]      pc_q, pc_d;
  logic [7:0]      pch_q, pch_d;

  // result buffer
  ufe_pkg::out_item_t [1:0] slot_q, slot_d;
  logic [1:0]               count_q, count_d;

  logic                     in_xfer, out_xfer;
  logic [ufe_pkg::CAP_W-1:0] cap_eff;
  logic [3:0]               klim, kl;
  logic [7:0]               key_ch;
  ufe_pkg::step_t           st;

  // ------------------------------------------------------------------
  // decode helpers
  // ------------------------------------------------------------------
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
    return v;
  endfunction

  function automatic logic [7:0] decode_pair(logic [7:0] a, logic [7:0] b);
    logic [4:0] da;
    logic [4:0] db;
    logic [7:0] r;
    da = hex_val(a);
    db = hex_val(b);
    r  = 8'h00;
    if (da[4]) begin
      r = db[4] ? {da[3:0], db[3:0]} : {4'h0, da[3:0]};
    end else if (a == ufe_pkg::CH_SPACE || (a >= ufe_pkg::CH_TAB && a <= ufe_pkg::CH_CR)
                 || a == ufe_pkg::CH_PLUS) begin
      r = db[4] ? {4'h0, db[3:0]} : 8'h00;
    end else if (a == ufe_pkg::CH_MINUS) begin
      r = db[4] ? (8'h00 - {4'h0, db[3:0]}) : 8'h00;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // step helpers
  // ------------------------------------------------------------------
  function automatic ufe_pkg::step_t push(ufe_pkg::step_t s, logic [7:0] b, logic v);
    ufe_pkg::step_t r;
    r = s;
    if (r.n < 2'd2) begin
      r.res[r.n[0]].value_byte  = b;
      r.res[r.n[0]].value_valid = v;
      r.res[r.n[0]].key_found   = 1'b0;
      r.res[r.n[0]].lookup_done = 1'b0;
      r.res[r.n[0]].run_last    = 1'b0;
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  // done report rides on the last result, or stands alone
  function automatic ufe_pkg::step_t finish(ufe_pkg::step_t s, logic found);
    ufe_pkg::step_t r;
    r = s;
    if (r.n == 2'd0) r = push(r, ufe_pkg::CH_NUL, 1'b0);
    r.res[r.n[1]].key_found   = found;
    r.res[r.n[1]].lookup_done = 1'b1;
    r.phase = ufe_pkg::PH_DONE;
    r.pc    = 2'd0;
    return r;
  endfunction

  function automatic ufe_pkg::step_t emit(ufe_pkg::step_t s, logic [7:0] b,
                                          logic [ufe_pkg::CAP_W-1:0] cap);
    ufe_pkg::step_t r;
    r = push(s, b, 1'b1);
    r.ec = r.ec + 8'd1;
    if ({1'b0, r.ec} + 9'd1 >= cap) r = finish(r, 1'b1);
    return r;
  endfunction

  function automatic ufe_pkg::step_t value_char(ufe_pkg::step_t s, logic [7:0] c,
                                                logic [ufe_pkg::CAP_W-1:0] cap);
    ufe_pkg::step_t r;
    r = s;
    if (c == ufe_pkg::CH_AMP) r = finish(r, 1'b1);
    else if (c == ufe_pkg::CH_PLUS) r = emit(r, ufe_pkg::CH_SPACE, cap);
    else if (c == ufe_pkg::CH_PCT) r.pc = 2'd1;
    else r = emit(r, c, cap);
    return r;
  endfunction

  // end of text: flush a cut-short escape, then report
  function automatic ufe_pkg::step_t terminate(ufe_pkg::step_t s,
                                               logic [ufe_pkg::CAP_W-1:0] cap);
    ufe_pkg::step_t r;
    logic [1:0]     had;
    r = s;
    if (r.phase == ufe_pkg::PH_VALUE) begin
      if (r.pc != 2'd0) begin
        had  = r.pc;
        r.pc = 2'd0;
        r    = emit(r, ufe_pkg::CH_PCT, cap);
        if (had == 2'd2 && r.phase == ufe_pkg::PH_VALUE) r = value_char(r, r.pch, cap);
        // the held character was itself a percent sign
        if (r.phase == ufe_pkg::PH_VALUE && r.pc != 2'd0) begin
          r.pc = 2'd0;
          r    = emit(r, ufe_pkg::CH_PCT, cap);
        end
      end
      if (r.phase == ufe_pkg::PH_VALUE) r = finish(r, 1'b1);
    end else if (r.phase != ufe_pkg::PH_DONE) begin
      r = finish(r, 1'b0);
    end
    return r;
  endfunction

  function automatic ufe_pkg::step_t match_byte(ufe_pkg::step_t s, logic [7:0] c,
                                                logic [3:0] klen, logic [7:0] kc,
                                                logic [ufe_pkg::CAP_W-1:0] cap);
    ufe_pkg::step_t r;
    r = s;
    if (c == ufe_pkg::CH_AMP) begin
      r.phase = ufe_pkg::PH_MATCH;
      r.kp    = 4'd0;
    end else if (r.phase == ufe_pkg::PH_SKIP) begin
      r.phase = ufe_pkg::PH_SKIP;
    end else if (r.kp < klen) begin
      if (c == kc) r.kp = r.kp + 4'd1;
      else r.phase = ufe_pkg::PH_SKIP;
    end else if (c == ufe_pkg::CH_EQ) begin
      r.phase = ufe_pkg::PH_VALUE;
      r.ec    = 8'd0;
      r.pc    = 2'd0;
      if (cap <= 9'd1) r = finish(r, 1'b1);
    end else begin
      r.phase = ufe_pkg::PH_SKIP;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // effective key length and capacity
  // ------------------------------------------------------------------
  always_comb begin
    klim = (key_len_q > 4'(ufe_pkg::MAX_KEY_CHARS)) ? 4'(ufe_pkg::MAX_KEY_CHARS) : key_len_q;
    kl   = klim;
    for (int i = ufe_pkg::MAX_KEY_CHARS - 1; i >= 0; i--) begin
      if (4'(i) < klim && key_bytes_q[i*8 +: 8] == ufe_pkg::CH_NUL) kl = 4'(i);
    end
  end

  assign cap_eff = (cap_q == '0) ? 9'd1 :
                   (cap_q > 9'(ufe_pkg::MAX_CAPACITY)) ? 9'(ufe_pkg::MAX_CAPACITY) : cap_q;

  assign key_ch = key_bytes_q[{kp_q[2:0], 3'b000} +: 8];

  // ------------------------------------------------------------------
  // one byte step
  // ------------------------------------------------------------------
  always_comb begin
    st       = '0;
    st.phase = phase_q;
    st.kp    = kp_q;
    st.ec    = ec_q;
    st.pc    = pc_q;
    st.pch   = pch_q;
    if (in_data_i.body_byte == ufe_pkg::CH_NUL) begin
      st = terminate(st, cap_eff);
    end else if (phase_q == ufe_pkg::PH_MATCH || phase_q == ufe_pkg::PH_SKIP) begin
      st = match_byte(st, in_data_i.body_byte, kl, key_ch, cap_eff);
    end else if (phase_q == ufe_pkg::PH_VALUE) begin
      if (pc_q == 2'd1) begin
        st.pch = in_data_i.body_byte;
        st.pc  = 2'd2;
      end else if (pc_q == 2'd2) begin
        st.pc = 2'd0;
        st    = emit(st, decode_pair(pch_q, in_data_i.body_byte), cap_eff);
      end else begin
        st = value_char(st, in_data_i.body_byte, cap_eff);
      end
    end
    if (in_data_i.body_end) st = terminate(st, cap_eff);
    if (st.n != 2'd0) st.res[st.n[1]].run_last = 1'b1;
  end

  // next lookup state
  always_comb begin
    phase_d = phase_q;
    kp_d    = kp_q;
    ec_d    = ec_q;
    pc_d    = pc_q;
    pch_d   = pch_q;
    if (in_xfer) begin
      if (in_data_i.body_end) begin
        phase_d = ufe_pkg::PH_MATCH;
        kp_d    = 4'd0;
        ec_d    = 8'd0;
        pc_d    = 2'd0;
        pch_d   = 8'd0;
      end else begin
        phase_d = st.phase;
        kp_d    = st.kp;
        ec_d    = st.ec;
        pc_d    = st.pc;
        pch_d   = st.pch;
      end
    end
  end

  // ------------------------------------------------------------------
  // result buffer: filled only when it drains empty this cycle
  // ------------------------------------------------------------------
  assign in_ready_o  = (count_q == 2'd0) || (count_q == 2'd1 && out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign out_data_o  = slot_q[0];

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    if (in_xfer) begin
      slot_d  = st.res;
      count_d = st.n;
    end else if (out_xfer) begin
      slot_d[0] = slot_q[1];
      count_d   = count_q - 2'd1;
    end
  end

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q <= '0;
      key_len_q   <= '0;
      cap_q       <= 9'(ufe_pkg::MAX_CAPACITY);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ufe_pkg::CFG_KEY_BYTES:      key_bytes_q <= cfg_wdata_i;
        ufe_pkg::CFG_KEY_LENGTH:     key_len_q   <= cfg_wdata_i[ufe_pkg::KLEN_W-1:0];
        ufe_pkg::CFG_VALUE_CAPACITY: cap_q       <= cfg_wdata_i[ufe_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ufe_pkg::PH_MATCH;
      kp_q    <= '0;
      ec_q    <= '0;
      pc_q    <= '0;
      pch_q   <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      kp_q    <= kp_d;
      ec_q    <= ec_d;
      pc_q    <= pc_d;
      pch_q   <= pch_d;
      count_q <= count_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `UFE_ASSERT(a_full_blocks_input, (count_q != 2'd2) || !in_ready_o,
              "input ready while result buffer is full")
  `UFE_ASSERT(a_no_escape_outside_value, (phase_q == ufe_pkg::PH_VALUE) || (pc_q == 2'd0),
              "escape pending outside the value phase")
  `UFE_ASSERT_NEXT(a_body_end_resets, in_xfer && in_data_i.body_end,
                   phase_q == ufe_pkg::PH_MATCH && kp_q == 4'd0 && ec_q == 8'd0
                   && pc_q == 2'd0, "state not cleared after body end")
  `UFE_ASSERT_NEXT(a_open_lookup_reports, in_xfer && in_data_i.body_end
                   && phase_q != ufe_pkg::PH_DONE, out_valid_o,
                   "open lookup ended without a result")

endmodule

`default_nettype wire
